// ===== rtl/core/es2cd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch seconds to calendar date: shared constants
// Calendar constants, field widths and the month start table of the
// March-based year.
// ----------------------------------------------------------------------------
package es2cd_pkg;

    localparam int YEAR_W   = 13;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int OUT_FIELDS_W = YEAR_W + MONTH_W + DAY_W + HOUR_W + MINUTE_W + SECOND_W;
    localparam int OUT_W = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int TOD_W  = 17;
    localparam int DOE_W  = 18;
    localparam int YOE_W  = 9;
    localparam int DOY_W  = 9;
    localparam int MP_W   = 4;
    localparam int HREM_W = 12;

    localparam int SECS_PER_DAY_ODD = 675;
    localparam int SECS_DAY_SHIFT   = 7;
    localparam int SECS_PER_HOUR    = 3600;
    localparam int SECS_PER_MIN     = 60;
    localparam int DAYS_PER_400Y    = 146097;
    localparam int DAYS_PER_4Y      = 1460;
    localparam int DAYS_PER_YEAR    = 365;
    localparam int MONTH_SPAN_DIV   = 153;
    localparam int DAYS_TO_EPOCH    = 719468;

    localparam logic [DOE_W-1:0] CENT_1 = DOE_W'(36524);
    localparam logic [DOE_W-1:0] CENT_2 = DOE_W'(73048);
    localparam logic [DOE_W-1:0] CENT_3 = DOE_W'(109572);
    localparam logic [DOE_W-1:0] CENT_4 = DOE_W'(146096);

    localparam logic [YOE_W-1:0] YOE_100 = YOE_W'(100);
    localparam logic [YOE_W-1:0] YOE_200 = YOE_W'(200);
    localparam logic [YOE_W-1:0] YOE_300 = YOE_W'(300);

    localparam logic [MP_W-1:0] MP_JANUARY = MP_W'(10);

    function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
        logic [DOY_W-1:0] v;
        case (mp)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/es2cd_cdiv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch seconds to calendar date: constant divider
// Two-stage division by a constant: a reciprocal multiply gives an estimate
// that is at most one low, and the second stage corrects it and forms the
// remainder. A side bundle travels alongside with the same latency.
// ----------------------------------------------------------------------------
module es2cd_cdiv #(
    parameter int XW      = 18,
    parameter int DIVISOR = 365,
    parameter int QW      = 9,
    parameter int RW      = 9,
    parameter int SIDEW   = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [XW-1:0]    i_x,
    input  logic [SIDEW-1:0] i_side,
    output logic [QW-1:0]    o_quo,
    output logic [RW-1:0]    o_rem,
    output logic [SIDEW-1:0] o_side
);

    localparam longint unsigned RECIP = (64'd1 << XW) / DIVISOR;
    localparam int RECW = $clog2(RECIP + 1);
    localparam logic [RECW-1:0] RECIP_V = RECW'(RECIP);
    localparam logic [XW-1:0] DIV_V = XW'(DIVISOR);

    logic [XW+RECW-1:0] w_prod;
    logic [XW-1:0]      w_back;
    logic [XW-1:0]      w_rem;
    logic               w_fix;

    logic [XW-1:0]      r_x;
    logic [RECW-1:0]    r_est;
    logic [SIDEW-1:0]   r_side;
    logic [QW-1:0]      r_quo;
    logic [RW-1:0]      r_rem;
    logic [SIDEW-1:0]   r_side_q;

    assign w_prod = (XW+RECW)'(i_x) * (XW+RECW)'(RECIP_V);
    assign w_back = XW'(r_est) * DIV_V;
    assign w_rem  = r_x - w_back;
    assign w_fix  = (w_rem >= DIV_V);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x      <= i_x;
            r_est    <= w_prod[XW+RECW-1:XW];
            r_side   <= i_side;
            r_quo    <= QW'(r_est + RECW'(w_fix));
            r_rem    <= RW'(w_fix ? w_rem - DIV_V : w_rem);
            r_side_q <= r_side;
        end
    end

    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
    assign o_side = r_side_q;

endmodule

// ===== rtl/core/epoch_seconds_to_calendar_date.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch seconds to calendar date
// Converts seconds since 1970-01-01 00:00:00 into civil year, month, day,
// hour, minute and second through a pipeline of constant dividers.
// Throughput: one item per cycle; the whole pipeline holds while the output
// register is full and not taken, set by the single shared stall enable.
// Reset clears the valid bits only; the data registers are not reset.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_date #(
    parameter int SECONDS_WIDTH = 36,
    localparam int IN_W = ((SECONDS_WIDTH + 7) / 8) * 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    // epoch_seconds
    input  logic [IN_W-1:0]         i_s_axis_tdata,
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    // year, month_index, day_of_month, hour, minute, second_of_minute
    output logic [es2cd_pkg::OUT_W-1:0] o_m_axis_tdata
);

    import es2cd_pkg::*;

    localparam int LAT  = 14;
    localparam int XD_W = SECONDS_WIDTH - SECS_DAY_SHIFT;
    localparam int DAYW = SECONDS_WIDTH - 16;
    localparam int ZW   = ((DAYW >= 20) ? DAYW : 20) + 1;
    localparam int EW   = ZW - 17;
    localparam int RD_W = 10;
    localparam int L4_W = 7;
    localparam int MP_SIDE_W = EW + YOE_W + DOY_W + HOUR_W + MINUTE_W + SECOND_W;

    logic               w_en;
    logic [LAT-1:0]     r_vld;

    logic [DAYW-1:0]    w_days;
    logic [RD_W-1:0]    w_day_rem;
    logic [SECS_DAY_SHIFT-1:0] w_sec_lo;
    logic [ZW-1:0]      r_z;
    logic [TOD_W-1:0]   r_tod;

    logic [EW-1:0]      w_era;
    logic [DOE_W-1:0]   w_doe;
    logic [TOD_W-1:0]   w_tod;
    logic [2:0]         w_cent;
    logic               w_quad;

    logic [L4_W-1:0]    w_leap4;
    logic               w_quad_d;
    logic [2:0]         w_cent_d;
    logic [DOE_W-1:0]   w_doe_d;
    logic [HOUR_W-1:0]  w_hour;
    logic [HREM_W-1:0]  w_hrem;
    logic [EW-1:0]      w_era_d;

    logic [DOE_W-1:0]   r_n;
    logic [DOE_W-1:0]   r_doe;
    logic [EW-1:0]      r_era;
    logic [HOUR_W-1:0]  r_hour;
    logic [HREM_W-1:0]  r_hrem;

    logic [YOE_W-1:0]   w_yoe;
    logic [EW-1:0]      w_era_e;
    logic [DOE_W-1:0]   w_doe_e;
    logic [MINUTE_W-1:0] w_minute;
    logic [SECOND_W-1:0] w_second;
    logic [HOUR_W-1:0]  w_hour_e;
    logic [1:0]         w_c100;
    logic [DOE_W-1:0]   w_ystart;

    logic [YOE_W-1:0]   r_yoe;
    logic [EW-1:0]      r_era2;
    logic [DOY_W-1:0]   r_doy;
    logic [HOUR_W-1:0]  r_hour2;
    logic [MINUTE_W-1:0] r_minute;
    logic [SECOND_W-1:0] r_second;
    logic [10:0]        w_mp_num;

    logic [MP_W-1:0]    w_mp;
    logic [MP_SIDE_W-1:0] w_mp_side;
    logic [EW-1:0]      w_era_f;
    logic [YOE_W-1:0]   w_yoe_f;
    logic [DOY_W-1:0]   w_doy_f;
    logic [HOUR_W-1:0]  w_hour_f;
    logic [MINUTE_W-1:0] w_minute_f;
    logic [SECOND_W-1:0] w_second_f;
    logic               w_jan_feb;
    logic [MONTH_W-1:0] w_month;
    logic [DAY_W-1:0]   w_day;
    logic [YEAR_W-1:0]  w_year;

    logic [OUT_W-1:0]   r_tdata;

    assign w_en            = !r_vld[LAT-1] || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_vld[LAT-1];
    assign o_m_axis_tdata  = r_tdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_axis_tvalid};
        end
    end

    es2cd_cdiv #(
        .XW(XD_W), .DIVISOR(SECS_PER_DAY_ODD), .QW(DAYW), .RW(RD_W), .SIDEW(SECS_DAY_SHIFT)
    ) u_day (
        .i_clk(i_clk), .i_en(w_en),
        .i_x(i_s_axis_tdata[SECONDS_WIDTH-1:SECS_DAY_SHIFT]),
        .i_side(i_s_axis_tdata[SECS_DAY_SHIFT-1:0]),
        .o_quo(w_days), .o_rem(w_day_rem), .o_side(w_sec_lo)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_z   <= ZW'(w_days) + ZW'(DAYS_TO_EPOCH);
            r_tod <= {w_day_rem, w_sec_lo};
        end
    end

    es2cd_cdiv #(
        .XW(ZW), .DIVISOR(DAYS_PER_400Y), .QW(EW), .RW(DOE_W), .SIDEW(TOD_W)
    ) u_era (
        .i_clk(i_clk), .i_en(w_en), .i_x(r_z), .i_side(r_tod),
        .o_quo(w_era), .o_rem(w_doe), .o_side(w_tod)
    );

    assign w_cent = 3'(w_doe >= CENT_1) + 3'(w_doe >= CENT_2)
                  + 3'(w_doe >= CENT_3) + 3'(w_doe >= CENT_4);
    assign w_quad = (w_doe == CENT_4);

    es2cd_cdiv #(
        .XW(DOE_W), .DIVISOR(DAYS_PER_4Y), .QW(L4_W), .RW(11), .SIDEW(DOE_W + 4)
    ) u_leap4 (
        .i_clk(i_clk), .i_en(w_en), .i_x(w_doe), .i_side({w_quad, w_cent, w_doe}),
        .o_quo(w_leap4), .o_rem(), .o_side({w_quad_d, w_cent_d, w_doe_d})
    );

    es2cd_cdiv #(
        .XW(TOD_W), .DIVISOR(SECS_PER_HOUR), .QW(HOUR_W), .RW(HREM_W), .SIDEW(EW)
    ) u_hour (
        .i_clk(i_clk), .i_en(w_en), .i_x(w_tod), .i_side(w_era),
        .o_quo(w_hour), .o_rem(w_hrem), .o_side(w_era_d)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_n    <= w_doe_d - DOE_W'(w_leap4) + DOE_W'(w_cent_d) - DOE_W'(w_quad_d);
            r_doe  <= w_doe_d;
            r_era  <= w_era_d;
            r_hour <= w_hour;
            r_hrem <= w_hrem;
        end
    end

    es2cd_cdiv #(
        .XW(DOE_W), .DIVISOR(DAYS_PER_YEAR), .QW(YOE_W), .RW(9), .SIDEW(EW + DOE_W)
    ) u_yoe (
        .i_clk(i_clk), .i_en(w_en), .i_x(r_n), .i_side({r_era, r_doe}),
        .o_quo(w_yoe), .o_rem(), .o_side({w_era_e, w_doe_e})
    );

    es2cd_cdiv #(
        .XW(HREM_W), .DIVISOR(SECS_PER_MIN), .QW(MINUTE_W), .RW(SECOND_W), .SIDEW(HOUR_W)
    ) u_min (
        .i_clk(i_clk), .i_en(w_en), .i_x(r_hrem), .i_side(r_hour),
        .o_quo(w_minute), .o_rem(w_second), .o_side(w_hour_e)
    );

    assign w_c100   = 2'(w_yoe >= YOE_100) + 2'(w_yoe >= YOE_200) + 2'(w_yoe >= YOE_300);
    assign w_ystart = DOE_W'(w_yoe) * DOE_W'(DAYS_PER_YEAR) + DOE_W'(w_yoe >> 2)
                    - DOE_W'(w_c100);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_yoe    <= w_yoe;
            r_era2   <= w_era_e;
            r_doy    <= DOY_W'(w_doe_e - w_ystart);
            r_hour2  <= w_hour_e;
            r_minute <= w_minute;
            r_second <= w_second;
        end
    end

    assign w_mp_num = {r_doy, 2'b00} + 11'(r_doy) + 11'd2;

    es2cd_cdiv #(
        .XW(11), .DIVISOR(MONTH_SPAN_DIV), .QW(MP_W), .RW(8), .SIDEW(MP_SIDE_W)
    ) u_mp (
        .i_clk(i_clk), .i_en(w_en), .i_x(w_mp_num),
        .i_side({r_era2, r_yoe, r_doy, r_hour2, r_minute, r_second}),
        .o_quo(w_mp), .o_rem(), .o_side(w_mp_side)
    );

    assign {w_era_f, w_yoe_f, w_doy_f, w_hour_f, w_minute_f, w_second_f} = w_mp_side;

    assign w_jan_feb = (w_mp >= MP_JANUARY);
    assign w_month   = w_jan_feb ? w_mp - MP_JANUARY : w_mp + MONTH_W'(2);
    assign w_day     = DAY_W'(w_doy_f - month_start(w_mp) + DOY_W'(1));
    assign w_year    = YEAR_W'(w_yoe_f) + YEAR_W'(w_era_f) * YEAR_W'(400)
                     + YEAR_W'(w_jan_feb);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tdata <= OUT_W'({w_second_f, w_minute_f, w_hour_f, w_day, w_month, w_year});
        end
    end

`ifndef SYNTH
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[16:13] <= 4'd11)
                         && (o_m_axis_tdata[21:17] != 5'd0))
        else $error("month or day of month out of range");

    a_clock_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[26:22] <= 5'd23)
                         && (o_m_axis_tdata[32:27] <= 6'd59)
                         && (o_m_axis_tdata[38:33] <= 6'd59))
        else $error("time of day out of range");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");
`endif

endmodule
